// ===== rtl/core/stmm_pkg.sv =====
// shared constants, types and helpers of the span tracker
package stmm_pkg;

   localparam int DATA_W          = 32;
   localparam int CAP_W           = 11;
   localparam int COUNT_OUT_W     = 11;
   localparam int DEF_MAX_ENTRIES = 1024;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // register index of capacity within the csr map
   localparam logic [0:0] REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1);

   typedef struct packed {
      logic              vld;
      logic [DATA_W-1:0] span;
   } dist_type;

   // signed compare of two's complement words
   function automatic logic below(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      below = $signed(a) < $signed(b);
   endfunction

endpackage

// ===== rtl/core/stmm_req_if.sv =====
// request channel carrying one value word
interface stmm_req_if import stmm_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/stmm_rsp_if.sv =====
// response channel carrying status, spans and count
interface stmm_rsp_if import stmm_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic                   spans_valid;
   logic [DATA_W-1:0]      shortest_span;
   logic [DATA_W-1:0]      longest_span;
   logic [COUNT_OUT_W-1:0] stored_count;

   modport source (output valid, output status, output spans_valid, output shortest_span,
                   output longest_span, output stored_count, input ready);
   modport sink (input valid, input status, input spans_valid, input shortest_span,
                 input longest_span, input stored_count, output ready);
endinterface

// ===== rtl/core/stmm_gap_unit.sv =====
// shared distance unit: absolute signed difference, one result per cycle
module stmm_gap_unit import stmm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output dist_type          result
);

   logic              vld_ff;
   logic              vld_in;
   logic [DATA_W-1:0] dist_ff;
   logic [DATA_W-1:0] dist_in;

   always_comb begin
      vld_in  = in_vld;
      dist_in = below(a, b) ? (b - a) : (a - b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      dist_ff <= dist_in;
   end

   assign result.vld  = vld_ff;
   assign result.span = dist_ff;

endmodule

// ===== rtl/core/span_tracker_min_max_gap_unit.sv =====
// top level of the span tracker: value store, scan sequencer, spans and csr
// path: a refused word goes from idle straight to done, the first stored word through finish,
//   otherwise scan first reads every held word, one store read per cycle, through the distance unit
// throughput: one word at a time; req ready again in the cycle its response word goes valid
// reset: synchronous active high; clears count, extremes, least gap (to all ones),
//   capacity (to 1) and the handshakes; store contents are not cleared
module span_tracker_min_max_gap_unit import stmm_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   stmm_req_if.sink              req_chan,
   stmm_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              issue_ff, issue_in;
   logic              rdv_ff, rdv_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic              refused_ff, refused_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [DATA_W-1:0] gap_ff, gap_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_spans_ff, rsp_spans_in;
   logic [DATA_W-1:0]      rsp_short_ff, rsp_short_in;
   logic [DATA_W-1:0]      rsp_long_ff, rsp_long_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // value store
   logic [DATA_W-1:0] store_mem [MAX_ENTRIES];
   logic [DATA_W-1:0] rdata_ff;
   logic              rd_en;
   logic              wr_en;

   dist_type          gap_res;
   logic [LIM_W-1:0]  cap_ext;
   logic [LIM_W-1:0]  limit;
   logic              full;
   logic [CNT_W-1:0]  held_last;
   logic              req_fire;
   logic              csr_wr;
   logic              spans_ok;

   // effective capacity saturates at the store depth
   assign cap_ext   = LIM_W'(capacity_ff);
   assign limit     = (cap_ext > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : cap_ext;
   assign full      = LIM_W'(held_ff) >= limit;
   assign held_last = held_ff - CNT_W'(1);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // csr port, single register, capacity lives at index zero
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W-2)'(REG_CAPACITY));
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W-2)'(REG_CAPACITY))
                       ? CSR_DATA_W'(capacity_ff) : '0;

   // store reads stream through the distance unit against the new word
   stmm_gap_unit u_gap (
      .clock  (clock),
      .reset  (reset),
      .in_vld (rdv_ff),
      .a      (x_ff),
      .b      (rdata_ff),
      .result (gap_res)
   );

   assign rd_en    = (state_ff == ST_SCAN) && issue_ff;
   assign wr_en    = (state_ff == ST_FINISH);
   assign spans_ok = held_ff >= CNT_W'(2);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      rdv_in       = rd_en;
      x_in         = x_ff;
      refused_in   = refused_ff;
      held_in      = held_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      gap_in       = gap_ff;
      capacity_in  = csr_wr ? csr_pwdata[CAP_W-1:0] : capacity_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_spans_in  = rsp_spans_ff;
      rsp_short_in  = rsp_short_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_count_in  = rsp_count_ff;

      // fold each distance into the least gap as it comes out
      if (gap_res.vld && (gap_res.span < gap_ff)) begin
         gap_in = gap_res.span;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in       = req_chan.value;
               refused_in = full;
               idx_in     = '0;
               if (full) begin
                  state_in = ST_DONE;
               end else if (held_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               idx_in = idx_ff + ADDR_W'(1);
               if (idx_ff == held_last[ADDR_W-1:0]) begin
                  issue_in = 1'b0;
               end
            end else if (!rdv_ff && !gap_res.vld) begin
               // pipeline drained, least gap is final
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (held_ff == '0) begin
               min_in = x_ff;
               max_in = x_ff;
            end else begin
               if (below(x_ff, min_ff)) begin
                  min_in = x_ff;
               end
               if (below(max_ff, x_ff)) begin
                  max_in = x_ff;
               end
            end
            held_in  = held_ff + CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = refused_ff;
               rsp_spans_in  = spans_ok;
               rsp_short_in  = spans_ok ? gap_ff : '0;
               rsp_long_in   = spans_ok ? (max_ff - min_ff) : '0;
               rsp_count_in  = COUNT_OUT_W'(held_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         held_ff      <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         gap_ff       <= '1;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         held_ff      <= held_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         gap_ff       <= gap_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      refused_ff    <= refused_in;
      rsp_status_ff <= rsp_status_in;
      rsp_spans_ff  <= rsp_spans_in;
      rsp_short_ff  <= rsp_short_in;
      rsp_long_ff   <= rsp_long_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[held_ff[ADDR_W-1:0]] <= x_ff;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[idx_ff];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.spans_valid   = rsp_spans_ff;
   assign rsp_chan.shortest_span = rsp_short_ff;
   assign rsp_chan.longest_span  = rsp_long_ff;
   assign rsp_chan.stored_count  = rsp_count_ff;

endmodule

// ===== rtl/core/stmm_checker.sv =====
// port-level checks of the span tracker, bound to the top level
module stmm_checker import stmm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_status,
   input logic                   rsp_spans_valid,
   input logic [DATA_W-1:0]      rsp_shortest,
   input logic [DATA_W-1:0]      rsp_longest,
   input logic [COUNT_OUT_W-1:0] rsp_count
);

   // a stalled response word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one word in flight: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // spans read zero without two stored values
   a_zero_spans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_spans_valid |-> (rsp_shortest == '0) && (rsp_longest == '0))
      else $error("spans nonzero while not valid");

   // valid spans need two stored values and fit under the range
   a_spans_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spans_valid |-> (rsp_count >= COUNT_OUT_W'(2))
                                       && (rsp_shortest <= rsp_longest))
      else $error("spans inconsistent with count");

   // an accepted word leaves at least one stored value
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_count != '0)
      else $error("accepted word with empty set");

endmodule

bind span_tracker_min_max_gap_unit stmm_checker u_stmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_spans_valid (rsp_chan.spans_valid),
   .rsp_shortest    (rsp_chan.shortest_span),
   .rsp_longest     (rsp_chan.longest_span),
   .rsp_count       (rsp_chan.stored_count)
);
